### rtl/ofp_pkg.sv
// Package for the offset frame parser.
// Holds frame byte constants and the result word type used by the parser, result register and top level.
// No dependencies.
package ofp_pkg;

  // Frame layout bytes.
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] TRAILER    = 8'h0D;

  // Offset pair that marks arrival instead of a new position.
  localparam logic [15:0] MARKER_VAL = 16'h7FFF;

  // Byte positions within a frame.
  localparam logic [2:0] POS_HDR2      = 3'd1;
  localparam logic [2:0] POS_PAY_FIRST = 3'd2;
  localparam logic [2:0] POS_PAY_LAST  = 3'd5;
  localparam logic [2:0] POS_TRAILER   = 3'd6;

  // One result word.
  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic               arrived;
  } res_t;

endpackage

### rtl/ofp_in_stage.sv
// Input register for the offset frame parser.
// Holds one received byte until the parser consumes it. Uses no package items.
module ofp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  // The register takes a new word when empty or when its word moves on.
  assign in_ready   = !valid_r || advance;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Byte payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

### rtl/ofp_parser.sv
// Frame parser state machine for the offset frame parser.
// Tracks header, payload and trailer bytes and keeps the held offsets.
// Depends on ofp_pkg.
module ofp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic [7:0]    byte_data,
  output logic          res_valid,
  output ofp_pkg::res_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR2 = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [7:0]         payload_r [4];
  logic               pay_wr;
  logic [1:0]         pay_idx;
  logic signed [15:0] held_x_r, held_x_nxt;
  logic signed [15:0] held_y_r, held_y_nxt;
  logic               arrived_r, arrived_nxt;
  logic [15:0]        frame_x;
  logic [15:0]        frame_y;

  // Offsets assembled big-endian from the stored payload.
  assign frame_x = {payload_r[0], payload_r[1]};
  assign frame_y = {payload_r[2], payload_r[3]};
  assign pay_idx = pos_r[1:0] - ofp_pkg::POS_PAY_FIRST[1:0];

  // Next-state and result decode for the current byte.
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    pay_wr      = 1'b0;
    res_valid   = 1'b0;
    held_x_nxt  = held_x_r;
    held_y_nxt  = held_y_r;
    arrived_nxt = arrived_r;
    unique case (phase_r)
      PH_HDR2: begin
        // A wrong second header byte is dropped, not retried as a start.
        if (byte_data == ofp_pkg::HDR_SECOND) begin
          phase_nxt = PH_BODY;
          pos_nxt   = ofp_pkg::POS_PAY_FIRST;
        end else begin
          phase_nxt = PH_IDLE;
          pos_nxt   = 3'd0;
        end
      end
      PH_BODY: begin
        if (pos_r >= ofp_pkg::POS_PAY_FIRST && pos_r <= ofp_pkg::POS_PAY_LAST) begin
          pay_wr  = 1'b1;
          pos_nxt = pos_r + 3'd1;
        end else begin
          phase_nxt = PH_IDLE;
          pos_nxt   = 3'd0;
          if (pos_r == ofp_pkg::POS_TRAILER && byte_data == ofp_pkg::TRAILER) begin
            res_valid = 1'b1;
            if (frame_x == ofp_pkg::MARKER_VAL && frame_y == ofp_pkg::MARKER_VAL) begin
              arrived_nxt = 1'b1;
            end else begin
              held_x_nxt = frame_x;
              held_y_nxt = frame_y;
            end
          end
        end
      end
      default: begin
        // Idle, and the unused phase code.
        if (byte_data == ofp_pkg::HDR_FIRST) begin
          phase_nxt = PH_HDR2;
          pos_nxt   = ofp_pkg::POS_HDR2;
        end else begin
          phase_nxt = PH_IDLE;
          pos_nxt   = 3'd0;
        end
      end
    endcase
  end

  // The result word carries the held values after this frame.
  assign res.offset_x = held_x_nxt;
  assign res.offset_y = held_y_nxt;
  assign res.arrived  = arrived_nxt;

  // Parser state and held offsets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= 3'd0;
      held_x_r  <= '0;
      held_y_r  <= '0;
      arrived_r <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      held_x_r  <= held_x_nxt;
      held_y_r  <= held_y_nxt;
      arrived_r <= arrived_nxt;
    end
  end

  // Payload byte store; every entry is written before it is read in a frame.
  always_ff @(posedge clk) begin
    if (advance && pay_wr) begin
      payload_r[pay_idx] <= byte_data;
    end
  end

`ifndef SYNTHESIS
  a_arrived_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    arrived_r |=> arrived_r)
    else $error("arrived flag cleared after being set");

  a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (pos_r >= ofp_pkg::POS_PAY_FIRST &&
                              pos_r <= ofp_pkg::POS_TRAILER))
    else $error("byte position out of range while collecting");

  a_hdr2_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR2) |-> (pos_r == ofp_pkg::POS_HDR2))
    else $error("byte position wrong while waiting for second header");

  a_res_at_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == PH_BODY && pos_r == ofp_pkg::POS_TRAILER))
    else $error("result raised outside the trailer byte");
`endif

endmodule

### rtl/ofp_out_stage.sv
// Result register for the offset frame parser.
// Holds one result word until the consumer takes it. Depends on ofp_pkg.
module ofp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               res_valid,
  input  ofp_pkg::res_t      res,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_offset_x,
  output logic signed [15:0] out_offset_y,
  output logic               out_arrived
);

  logic          valid_r;
  ofp_pkg::res_t res_r;

  // The slot can take a word when empty or when its word leaves this cycle.
  assign slot_free    = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign out_offset_x = res_r.offset_x;
  assign out_offset_y = res_r.offset_y;
  assign out_arrived  = res_r.arrived;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### rtl/offset_frame_parser_unit.sv
// Offset frame parser, top level: input register, parser, result register.
// A trailer byte waits in the input register, then its parser step
// registers the result and out_valid. Throughput: one word per cycle; any
// word waits while an untaken result holds the result register.
// Reset: synchronous active-low rst_n returns the parser to idle and clears the
// held offsets and the arrived flag. Depends on ofp_pkg and the ofp_* modules.
module offset_frame_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_offset_x,
  output logic signed [15:0] out_offset_y,
  output logic               out_arrived
);

  logic          byte_valid;
  logic [7:0]    byte_data;
  logic          slot_free;
  logic          advance;
  logic          res_valid;
  ofp_pkg::res_t res;

  // A byte moves through the parser when the result slot can take its word.
  assign advance = byte_valid && slot_free;

  ofp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ofp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ofp_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .res_valid    (res_valid),
    .res          (res),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_offset_x (out_offset_x),
    .out_offset_y (out_offset_y),
    .out_arrived  (out_arrived)
  );

endmodule

### sim/tb.sv
// Testbench for offset_frame_parser_unit: drives received bytes, predicts each
// frame result and checks it against the result channel under varied idling.
// Depends on ofp_pkg and the offset frame parser RTL.
module tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR2,
    PH_BODY
  } frame_phase_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [15:0] out_offset_x;
  logic signed [15:0] out_offset_y;
  logic              out_arrived;

  // Parser state as the checker sees it.
  frame_phase_t frame_phase = PH_IDLE;
  logic [2:0]   frame_pos = '0;
  logic [7:0]   payload [4];
  logic [15:0]  held_x = '0;
  logic [15:0]  held_y = '0;
  logic         arrived_seen = 1'b0;

  ofp_pkg::res_t frame_results_due [$];

  int error_count = 0;
  int cycle_count = 0;
  int bytes_taken = 0;
  int results_checked = 0;
  int marker_frames = 0;
  int dropped_frames = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  offset_frame_parser_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_offset_x (out_offset_x),
    .out_offset_y (out_offset_y),
    .out_arrived  (out_arrived)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, frame_results_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Advance the frame parser by one accepted word and queue any result.
  task automatic track_rx_byte(input logic [7:0] rx);
    ofp_pkg::res_t res;
    logic [15:0]   x;
    logic [15:0]   y;
    bytes_taken++;
    case (frame_phase)
      PH_HDR2: begin
        // A wrong second header byte is not retried as a frame start.
        if (rx == ofp_pkg::HDR_SECOND) begin
          frame_phase = PH_BODY;
          frame_pos = ofp_pkg::POS_PAY_FIRST;
        end else begin
          frame_phase = PH_IDLE;
          frame_pos = '0;
        end
      end
      PH_BODY: begin
        if (frame_pos >= ofp_pkg::POS_PAY_FIRST && frame_pos <= ofp_pkg::POS_PAY_LAST) begin
          payload[2'(frame_pos - ofp_pkg::POS_PAY_FIRST)] = rx;
          frame_pos = frame_pos + 3'd1;
        end else begin
          if (frame_pos == ofp_pkg::POS_TRAILER) begin
            if (rx != ofp_pkg::TRAILER) begin
              dropped_frames++;
            end else begin
              x = {payload[0], payload[1]};
              y = {payload[2], payload[3]};
              // A marker frame sets the sticky flag and keeps the offsets.
              if (x == ofp_pkg::MARKER_VAL && y == ofp_pkg::MARKER_VAL) begin
                arrived_seen = 1'b1;
                marker_frames++;
              end else begin
                held_x = x;
                held_y = y;
              end
              res.offset_x = held_x;
              res.offset_y = held_y;
              res.arrived = arrived_seen;
              frame_results_due.push_back(res);
            end
          end
          frame_phase = PH_IDLE;
          frame_pos = '0;
        end
      end
      default: begin
        if (rx == ofp_pkg::HDR_FIRST) begin
          frame_phase = PH_HDR2;
          frame_pos = ofp_pkg::POS_HDR2;
        end else begin
          frame_phase = PH_IDLE;
          frame_pos = '0;
        end
      end
    endcase
  endtask

  // Check each result word against the oldest expectation, then track inputs.
  always @(posedge clk) begin
    ofp_pkg::res_t due;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          error_count++;
          $display("%0t: expected no result, got x=%0d y=%0d arrived=%0b", $time,
                   out_offset_x, out_offset_y, out_arrived);
        end else begin
          due = frame_results_due.pop_front();
          results_checked++;
          if (out_offset_x !== due.offset_x) begin
            error_count++;
            $display("%0t: offset_x expected %0d, got %0d", $time,
                     due.offset_x, out_offset_x);
          end
          if (out_offset_y !== due.offset_y) begin
            error_count++;
            $display("%0t: offset_y expected %0d, got %0d", $time,
                     due.offset_y, out_offset_y);
          end
          if (out_arrived !== due.arrived) begin
            error_count++;
            $display("%0t: arrived expected %0b, got %0b", $time,
                     due.arrived, out_arrived);
          end
        end
      end
      if (in_valid && in_ready) begin
        track_rx_byte(in_rx_byte);
      end
    end
  end

  // Send one word, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
                            input logic [7:0] trailer);
    send_byte(ofp_pkg::HDR_FIRST);
    send_byte(ofp_pkg::HDR_SECOND);
    send_byte(x[15:8]);
    send_byte(x[7:0]);
    send_byte(y[15:8]);
    send_byte(y[7:0]);
    send_byte(trailer);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offsets lean toward the marker value and the signed extremes.
  function automatic logic [15:0] pick_offset();
    case ($urandom_range(9))
      0: return ofp_pkg::MARKER_VAL;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_noise_and_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'h8000, ofp_pkg::MARKER_VAL, ofp_pkg::TRAILER);
  endtask

  // An 0xAA in the second header slot drops back to idle, and the 0x55
  // that follows is just noise.
  task automatic test_wrong_second_header();
    send_byte(ofp_pkg::HDR_FIRST);
    send_byte(ofp_pkg::HDR_FIRST);
    send_byte(ofp_pkg::HDR_SECOND);
  endtask

  task automatic test_marker_frame();
    send_frame(ofp_pkg::MARKER_VAL, ofp_pkg::MARKER_VAL, ofp_pkg::TRAILER);
  endtask

  task automatic test_bad_trailer();
    send_frame(16'h1234, 16'h5678, 8'h0C);
  endtask

  // Mostly well-formed frames, plus bad trailers, wrong second headers, cut-off frames and noise.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
    int          sent;
    int          pick;
    int          cut;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  b;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(9) == 0) begin
          x = ofp_pkg::MARKER_VAL;
          y = ofp_pkg::MARKER_VAL;
        end else begin
          x = pick_offset();
          y = pick_offset();
        end
        send_frame(x, y, ofp_pkg::TRAILER);
        sent += 7;
      end else if (pick < 80) begin
        b = 8'($urandom);
        if (b == ofp_pkg::TRAILER) b = ~b;
        send_frame(pick_offset(), pick_offset(), b);
        sent += 7;
      end else if (pick < 87) begin
        b = 8'($urandom);
        if (b == ofp_pkg::HDR_SECOND) b = ofp_pkg::HDR_FIRST;
        send_byte(ofp_pkg::HDR_FIRST);
        send_byte(b);
        sent += 2;
      end else if (pick < 94) begin
        // Frame cut short; following words land in its payload or trailer.
        cut = $urandom_range(0, 3);
        send_byte(ofp_pkg::HDR_FIRST);
        send_byte(ofp_pkg::HDR_SECOND);
        repeat (cut) send_byte(8'($urandom));
        sent += 2 + cut;
      end else begin
        cut = $urandom_range(1, 4);
        repeat (cut) send_byte(8'($urandom));
        sent += cut;
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_noise_and_extremes();
    test_wrong_second_header();
    test_marker_frame();
    test_bad_trailer();
    wait_results_drained();

    test_random_traffic(0, 0, 310);
    test_random_traffic(47, 0, 310);
    test_random_traffic(0, 47, 310);
    test_random_traffic(33, 33, 310);

    $display("Sent %0d bytes across four idling phases; %0d frame results checked,",
             bytes_taken, results_checked);
    $display("%0d of them arrival markers, and %0d frames dropped on a bad trailer.",
             marker_frames, dropped_frames);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### offset_frame_parser_unit.f
rtl/ofp_pkg.sv
rtl/ofp_in_stage.sv
rtl/ofp_parser.sv
rtl/ofp_out_stage.sv
rtl/offset_frame_parser_unit.sv
sim/tb.sv
